FILE: sv/bba_pkg.sv
// Package for the buddy block allocator: tree sizes, status codes, op codes.
// No dependencies.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int unsigned TreeLevels = 10;
  localparam int unsigned PoolLog2   = 22;
  localparam int unsigned NodeCount  = 1 << TreeLevels;
  localparam int unsigned IdxW       = TreeLevels;
  localparam int unsigned LvlW       = 4;
  localparam int unsigned NeedW      = 25;

  localparam logic       OpAlloc     = 1'b0;
  localparam logic       OpFree      = 1'b1;
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatZero    = 2'd1;
  localparam logic [1:0] StatNoFit   = 2'd2;
  localparam logic [7:0] HeaderReset = 8'd40;

  // Byte size of a node at the given level, widened for compares.
  function automatic logic [NeedW-1:0] lvl_size(input logic [LvlW-1:0] lvl);
    logic [NeedW-1:0] one;
    one = NeedW'(1);
    return (one << PoolLog2) >> lvl;
  endfunction
endpackage

FILE: sv/buddy_block_allocator.sv
// Buddy block allocator top level: sequencer plus node state memory.
// Depends on bba_pkg.
//
// Usage: one input beat per operation (in_valid_i/in_stall_o), one result beat
// (out_valid_o/out_stall_i) per operation. op 0 allocates request_bytes plus
// header, op 1 frees block_addr at block_level. header_bytes is written through
// cfg_we_i/cfg_data_i; the user must write it only while idle (no check in block).
// Node marks live in a memory, {split, free} per node, one read and one write
// per cycle with registered read data.
// Sequence: an allocate visits nodes in preorder, each node read before it is
// checked, then splits down level by level; a free checks the target and its
// ancestors, then merges level by level, each merge reading the buddy, clearing
// both halves and freeing the parent. A zero-size request or a free beyond the
// deepest level goes straight to the output.
// One operation is in flight at a time; the next beat is taken once the
// sequencer is back in idle.
// Reset: a clearing pass over all NodeCount entries writes the node memory (root
// free, all else clear) with in_stall_o high; header is 40.
// When the receiver stalls, the result holds in the output register; the next
// operation may run but does not finish until that register is free.
`timescale 1ns / 1ps
module buddy_block_allocator import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [22:0] request_bytes_i,
  input  logic [21:0] block_addr_i,
  input  logic [3:0]  block_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [21:0] granted_addr_o,
  output logic [3:0]  granted_level_o
);
  localparam logic [3:0] SClr    = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SSrchRd = 4'd2;
  localparam logic [3:0] SSrch   = 4'd3;
  localparam logic [3:0] SSplit  = 4'd4;
  localparam logic [3:0] SSplitR = 4'd5;
  localparam logic [3:0] SChkRd  = 4'd6;
  localparam logic [3:0] SChk    = 4'd7;
  localparam logic [3:0] SMrgRd  = 4'd8;
  localparam logic [3:0] SMrg    = 4'd9;
  localparam logic [3:0] SMrgW1  = 4'd10;
  localparam logic [3:0] SMrgW2  = 4'd11;
  localparam logic [3:0] SOut    = 4'd12;

  // node entry: {split, free}
  localparam logic [1:0] NodeUsed  = 2'b00;
  localparam logic [1:0] NodeFree  = 2'b01;
  localparam logic [1:0] NodeSplit = 2'b10;

  logic [3:0]           st_q, st_d;
  logic [1:0]           node_mem [NodeCount];
  logic [1:0]           rd_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr, mem_raddr;
  logic [1:0]           mem_wdata;
  logic [7:0]           hdr_q;
  logic [NeedW-1:0]     need_q;
  logic [IdxW-1:0]      idx_q, tgt_q;
  logic [LvlW-1:0]      lvl_q;
  logic [1:0]           stat_q;
  logic [21:0]          gaddr_q;
  logic [3:0]           glvl_q;
  logic                 out_vld_q;
  logic [1:0]           ostat_q;
  logic [21:0]          oaddr_q;
  logic [3:0]           olvl_q;
  logic [NeedW-1:0]     sz;
  logic [IdxW-1:0]      idx2, idx2p1;
  logic                 fits, do_split, out_load;

  assign sz         = lvl_size(lvl_q);
  assign idx2       = {idx_q[IdxW-2:0], 1'b0};
  assign idx2p1     = {idx_q[IdxW-2:0], 1'b1};
  assign fits       = (sz >= need_q);
  assign do_split   = (lvl_q + 1'b1 < LvlW'(TreeLevels)) &&
                      (need_q + NeedW'(hdr_q) <= (sz >> 1));
  assign out_load   = (st_q == SOut) && (!out_vld_q || !out_stall_i);
  assign mem_raddr  = (st_q == SMrgRd) ? (idx_q ^ IdxW'(1)) : idx_q;
  assign in_stall_o = (st_q != SIdle);
  assign out_valid_o     = out_vld_q;
  assign status_o        = ostat_q;
  assign granted_addr_o  = oaddr_q;
  assign granted_level_o = olvl_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (in_valid_i) st_d = (op_i == OpFree) ? SChkRd : SSrchRd;
      SOut:  if (out_load) st_d = SIdle;
      default: ;
    endcase
  end

  // node memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = NodeUsed;
    unique case (st_q)
      SClr: begin
        mem_we    = 1'b1;
        mem_wdata = (idx_q == IdxW'(1)) ? NodeFree : NodeUsed;
      end
      SSplit: begin
        mem_we    = 1'b1;
        mem_wdata = do_split ? NodeSplit : NodeUsed;
      end
      SSplitR: begin
        mem_we    = 1'b1;
        mem_waddr = idx2p1;
        mem_wdata = NodeFree;
      end
      SChk: begin
        if (idx_q == tgt_q) begin
          // whole pool comes back, nothing above it to merge
          if (rd_q == NodeUsed && idx_q == IdxW'(1)) begin
            mem_we    = 1'b1;
            mem_wdata = NodeFree;
          end
        end else if (rd_q[1] && idx_q == IdxW'(1)) begin
          mem_we    = 1'b1;
          mem_waddr = tgt_q;
          mem_wdata = NodeFree;
        end
      end
      SMrg: begin
        if (rd_q[0]) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q ^ IdxW'(1);
        end
      end
      SMrgW1: mem_we = 1'b1;
      SMrgW2: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q >> 1;
        mem_wdata = NodeFree;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) node_mem[mem_waddr] <= mem_wdata;
    rd_q <= node_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SClr;
      hdr_q     <= HeaderReset;
      need_q    <= '0;
      idx_q     <= '0;
      tgt_q     <= '0;
      lvl_q     <= '0;
      stat_q    <= StatOk;
      gaddr_q   <= '0;
      glvl_q    <= '0;
      out_vld_q <= 1'b0;
      ostat_q   <= StatOk;
      oaddr_q   <= '0;
      olvl_q    <= '0;
    end else begin
      if (cfg_we_i) hdr_q <= cfg_data_i;
      if (out_load) begin
        out_vld_q <= 1'b1;
        ostat_q   <= stat_q;
        oaddr_q   <= gaddr_q;
        olvl_q    <= glvl_q;
      end else if (!out_stall_i) out_vld_q <= 1'b0;
      unique case (st_q)
        SClr: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == IdxW'(NodeCount - 1)) st_q <= SIdle;
        end
        SIdle: begin
          if (in_valid_i) begin
            stat_q  <= StatOk;
            gaddr_q <= '0;
            glvl_q  <= '0;
            need_q  <= NeedW'(request_bytes_i) + NeedW'(hdr_q);
            if (op_i == OpFree) begin
              // target node index; level beyond tree means ignore
              if (block_level_i < LvlW'(TreeLevels)) begin
                tgt_q <= IdxW'((IdxW'(1) << block_level_i) |
                        IdxW'(block_addr_i >> (PoolLog2 - block_level_i)));
                idx_q <= IdxW'((IdxW'(1) << block_level_i) |
                        IdxW'(block_addr_i >> (PoolLog2 - block_level_i)));
                st_q  <= SChkRd;
              end else st_q <= SOut;
            end else if (request_bytes_i == '0) begin
              stat_q <= StatZero;
              st_q   <= SOut;
            end else begin
              idx_q <= IdxW'(1);
              lvl_q <= '0;
              st_q  <= SSrchRd;
            end
          end
        end
        SSrchRd: st_q <= SSrch;
        SSrch: begin
          // preorder walk: descend, else go to next right sibling up the path
          if (fits && rd_q[0]) st_q <= SSplit;
          else if (fits && rd_q[1] && lvl_q + 1'b1 < LvlW'(TreeLevels)) begin
            idx_q <= idx2;
            lvl_q <= lvl_q + 1'b1;
            st_q  <= SSrchRd;
          end else begin
            logic [IdxW-1:0] n;
            logic [LvlW-1:0] l;
            n = idx_q;
            l = lvl_q;
            for (int k = 0; k < TreeLevels; k++) begin
              if (n[0] && n != IdxW'(1)) begin
                n = n >> 1;
                l = l - 1'b1;
              end
            end
            if (n == IdxW'(1)) begin
              stat_q <= StatNoFit;
              st_q   <= SOut;
            end else begin
              idx_q <= n + 1'b1;
              lvl_q <= l;
              st_q  <= SSrchRd;
            end
          end
        end
        SSplit: begin
          if (do_split) st_q <= SSplitR;
          else begin
            gaddr_q <= 22'(idx_q & ~(IdxW'(1) << lvl_q)) << (PoolLog2 - lvl_q);
            glvl_q  <= lvl_q;
            st_q    <= SOut;
          end
        end
        SSplitR: begin
          // left half goes on, right half was marked free
          idx_q <= idx2;
          lvl_q <= lvl_q + 1'b1;
          st_q  <= SSplit;
        end
        SChkRd: st_q <= SChk;
        SChk: begin
          // idx_q walks up from target; target must be allocated, ancestors split
          if (idx_q == tgt_q) begin
            if (rd_q != NodeUsed || idx_q == IdxW'(1)) st_q <= SOut;
            else begin
              idx_q <= idx_q >> 1;
              st_q  <= SChkRd;
            end
          end else if (!rd_q[1]) st_q <= SOut;
          else if (idx_q == IdxW'(1)) begin
            idx_q <= tgt_q;
            st_q  <= SMrgRd;
          end else begin
            idx_q <= idx_q >> 1;
            st_q  <= SChkRd;
          end
        end
        // idx_q is a free child; merge into its parent while the buddy is free
        SMrgRd: st_q <= SMrg;
        SMrg: begin
          if (rd_q[0]) st_q <= SMrgW1;
          else st_q <= SOut;
        end
        SMrgW1: st_q <= SMrgW2;
        SMrgW2: begin
          idx_q <= idx_q >> 1;
          if ((idx_q >> 1) == IdxW'(1)) st_q <= SOut;
          else st_q <= SMrgRd;
        end
        SOut: st_q <= st_d;
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
